>>> design/wmmcd_pkg.sv
package wmmcd_pkg;

   // Column bookkeeping.
   localparam int MAX_COLUMNS = 4096;
   localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
   localparam logic [COL_IDX_W-1:0] LAST_COLUMN = COL_IDX_W'(MAX_COLUMNS - 1);

   // Field widths fixed by the item layout.
   localparam int SAMPLE_W = 16;
   localparam int EXT_W    = 17;
   localparam int COLUMN_W = 12;
   localparam int ROW_W    = 14;
   localparam int PIX_W    = 12;
   localparam int BIN_W    = 16;

   // Width of the extreme times plot height product.
   localparam int PROD_W   = EXT_W + PIX_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_BIN_SIZE    = 8'd0;
   localparam csr_index_type CSR_SIXTEEN_BIT = 8'd1;
   localparam csr_index_type CSR_PLOT_HEIGHT = 8'd2;
   localparam csr_index_type CSR_Y_MIDDLE    = 8'd3;

   // What the accumulator hands to the row stage for the item in flight.
   typedef struct packed {
      logic                        emit;
      logic                        final_column;
      logic signed [EXT_W-1:0]     ext_max;
      logic signed [EXT_W-1:0]     ext_min;
      logic [COLUMN_W-1:0]         column;
   } accum_result_type;

endpackage

>>> design/wmmcd_if.sv
// Sample channel: one PCM sample per item.
interface wmmcd_req_if;
   logic                              valid;
   logic                              ready;
   logic [wmmcd_pkg::SAMPLE_W-1:0]    sample_raw;
   logic                              is_last;

   modport source (output valid, sample_raw, is_last, input ready);
   modport sink   (input valid, sample_raw, is_last, output ready);
endinterface

// Result channel: one column envelope per item.
interface wmmcd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [wmmcd_pkg::COLUMN_W-1:0]    column;
   logic signed [wmmcd_pkg::ROW_W-1:0] y_high;
   logic signed [wmmcd_pkg::ROW_W-1:0] y_low;
   logic                              final_column;

   modport source (output valid, column, y_high, y_low, final_column, input ready);
   modport sink   (input valid, column, y_high, y_low, final_column, output ready);
endinterface

// Configuration write channel.
interface wmmcd_csr_if;
   logic                              valid;
   logic                              ready;
   wmmcd_pkg::csr_index_type          index;
   logic [wmmcd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/waveform_min_max_column_decimator.sv
// Min/max column decimator for waveform display.
//
// Samples enter on req_ch, one item per sample, with is_last marking the end
// of a clip. Each sample is folded into the running maximum and minimum of the
// current display column; when bin_size samples have arrived, or on the last
// sample, one item leaves on rsp_ch with the column index and the pixel rows of
// both extremes. Other samples produce no result.
// Registers are written on csr_ch, which is always ready; write them only
// while no sample is in flight.
// An accepted sample is held in the sample register, and its result is then
// loaded into the result register. Throughput is one sample per cycle while
// rsp_ch does not stall, since all the work for a sample is one pass of logic
// between the sample register and the result register. When rsp_ch stalls,
// the result register holds its item. Samples that do not close a column keep
// flowing through the sample register; the first one that would close a
// column waits there, and req_ch drops ready until the waiting result is taken.
// Synchronous reset clears the column index, the extremes and the sample count
// and restores the register defaults (bin_size 1, 8-bit mode, height and
// middle row 0).
module waveform_min_max_column_decimator (
   input  logic              clock,
   input  logic              reset,
   wmmcd_req_if.sink         req_ch,
   wmmcd_rsp_if.source       rsp_ch,
   wmmcd_csr_if.sink         csr_ch
);

   logic [wmmcd_pkg::BIN_W-1:0]        bin_size_ff;
   logic                               sixteen_bit_ff;
   logic [wmmcd_pkg::PIX_W-1:0]        plot_height_ff;
   logic [wmmcd_pkg::PIX_W-1:0]        y_middle_ff;

   logic                               s1_valid_ff, s1_valid_in;
   logic [wmmcd_pkg::SAMPLE_W-1:0]     s1_sample_ff;
   logic                               s1_last_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [wmmcd_pkg::COLUMN_W-1:0]     rsp_column_ff;
   logic signed [wmmcd_pkg::ROW_W-1:0] rsp_high_ff, rsp_low_ff, high_row, low_row;
   logic                               rsp_final_ff;

   wmmcd_pkg::accum_result_type        res;
   logic                               out_free, s1_step, load_rsp, req_take;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff    <= wmmcd_pkg::BIN_W'(1);
         sixteen_bit_ff <= 1'b0;
         plot_height_ff <= '0;
         y_middle_ff    <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            wmmcd_pkg::CSR_BIN_SIZE:    bin_size_ff    <= csr_ch.data;
            wmmcd_pkg::CSR_SIXTEEN_BIT: sixteen_bit_ff <= csr_ch.data[0];
            wmmcd_pkg::CSR_PLOT_HEIGHT: plot_height_ff <= csr_ch.data[wmmcd_pkg::PIX_W-1:0];
            wmmcd_pkg::CSR_Y_MIDDLE:    y_middle_ff    <= csr_ch.data[wmmcd_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Flow control: the sample register moves on unless its item closes a
   // column while the result register is still occupied.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_step      = s1_valid_ff && (!res.emit || out_free);
   assign load_rsp     = s1_step && res.emit;
   assign req_ch.ready = !s1_valid_ff || s1_step;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take ? 1'b1 : (s1_step ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Sample register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_ch.sample_raw;
         s1_last_ff   <= req_ch.is_last;
      end
   end

   // Column extremes and bin counting.
   wmmcd_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_step),
      .sample_raw  (s1_sample_ff),
      .is_last     (s1_last_ff),
      .sixteen_bit (sixteen_bit_ff),
      .bin_size    (bin_size_ff),
      .result      (res)
   );

   // Pixel rows for both extremes.
   wmmcd_row u_row_high (
      .extreme     (res.ext_max),
      .plot_height (plot_height_ff),
      .y_middle    (y_middle_ff),
      .sixteen_bit (sixteen_bit_ff),
      .row         (high_row)
   );

   wmmcd_row u_row_low (
      .extreme     (res.ext_min),
      .plot_height (plot_height_ff),
      .y_middle    (y_middle_ff),
      .sixteen_bit (sixteen_bit_ff),
      .row         (low_row)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_column_ff <= res.column;
         rsp_high_ff   <= high_row;
         rsp_low_ff    <= low_row;
         rsp_final_ff  <= res.final_column;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.column       = rsp_column_ff;
   assign rsp_ch.y_high       = rsp_high_ff;
   assign rsp_ch.y_low        = rsp_low_ff;
   assign rsp_ch.final_column = rsp_final_ff;

   // A result appears only after a sample that closed a column.
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load_rsp))
      else $error("result valid without a closing sample");

   // A closing sample always lands in the result register.
   a_step_loads: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("closing sample lost");

   // The sample channel stalls only behind a waiting result.
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && res.emit && rsp_valid_ff && !rsp_ch.ready))
      else $error("sample channel stalled without cause");

endmodule

>>> design/wmmcd_accum.sv
module wmmcd_accum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [wmmcd_pkg::SAMPLE_W-1:0]    sample_raw,
   input  logic                              is_last,
   input  logic                              sixteen_bit,
   input  logic [wmmcd_pkg::BIN_W-1:0]       bin_size,
   output wmmcd_pkg::accum_result_type       result
);

   logic [wmmcd_pkg::BIN_W-1:0]         count_ff, count_in, count_inc, limit;
   logic signed [wmmcd_pkg::EXT_W-1:0]  max_ff, max_in, min_ff, min_in;
   logic signed [wmmcd_pkg::EXT_W-1:0]  value, new_max, new_min;
   logic [wmmcd_pkg::COL_IDX_W-1:0]     col_ff, col_in;
   logic                                emit;

   // Decode the sample: signed 16-bit, or the low byte offset by 128.
   always_comb begin
      if (sixteen_bit) begin
         value = {sample_raw[15], sample_raw};
      end else begin
         value = {{9{~sample_raw[7]}}, ~sample_raw[7], sample_raw[6:0]};
      end
   end

   // Fold the sample into the column extremes and decide whether it closes the column.
   assign new_max   = (value > max_ff) ? value : max_ff;
   assign new_min   = (value < min_ff) ? value : min_ff;
   assign count_inc = count_ff + 1'b1;
   assign limit     = (bin_size == '0) ? wmmcd_pkg::BIN_W'(1) : bin_size;
   assign emit      = (count_inc >= limit) || (count_inc == '0) || is_last;

   assign result.emit         = emit;
   assign result.final_column = is_last;
   assign result.ext_max      = new_max;
   assign result.ext_min      = new_min;
   assign result.column       = wmmcd_pkg::COLUMN_W'(col_ff);

   // Next state: clear after a closed column, column index saturates.
   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      col_in   = col_ff;
      if (step) begin
         if (emit) begin
            count_in = '0;
            max_in   = '0;
            min_in   = '0;
            if (col_ff != wmmcd_pkg::LAST_COLUMN) begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            count_in = count_inc;
            max_in   = new_max;
            min_in   = new_min;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= '0;
         min_ff   <= '0;
         col_ff   <= '0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         col_ff   <= col_in;
      end
   end

endmodule

>>> design/wmmcd_row.sv
module wmmcd_row (
   input  logic signed [wmmcd_pkg::EXT_W-1:0]  extreme,
   input  logic [wmmcd_pkg::PIX_W-1:0]         plot_height,
   input  logic [wmmcd_pkg::PIX_W-1:0]         y_middle,
   input  logic                                sixteen_bit,
   output logic signed [wmmcd_pkg::ROW_W-1:0]  row
);

   logic                                  neg;
   logic [wmmcd_pkg::EXT_W-1:0]           mag;
   logic [wmmcd_pkg::PROD_W-1:0]          prod;
   logic [wmmcd_pkg::PROD_W:0]            div_sum;
   logic [wmmcd_pkg::ROW_W-1:0]           q8, q16, quot, offset;

   // Work on the magnitude so the quotient truncates toward zero.
   assign neg  = extreme[wmmcd_pkg::EXT_W-1];
   assign mag  = neg ? (~extreme + 1'b1) : extreme;
   assign prod = wmmcd_pkg::PROD_W'(mag) * wmmcd_pkg::PROD_W'(plot_height);

   // Divide by 128 with a shift; divide by 65535 as (x + x/65536 + 1) / 65536,
   // which is exact for every product this width can hold.
   assign q8      = prod[7 +: wmmcd_pkg::ROW_W];
   assign div_sum = (wmmcd_pkg::PROD_W + 1)'(prod) + (wmmcd_pkg::PROD_W + 1)'(prod >> 16)
                    + 1'b1;
   assign q16     = div_sum[16 +: wmmcd_pkg::ROW_W];
   assign quot    = sixteen_bit ? q16 : q8;

   // Apply the sign and offset from the zero line; rows wrap to 14 bits.
   assign offset = neg ? (~quot + 1'b1) : quot;
   assign row    = wmmcd_pkg::ROW_W'(y_middle) + offset;

endmodule
